@@ src/sitda_pkg.sv @@
// Shared constants and helpers for the signed integer to decimal text converter.
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CHAR_W         = 6;
  localparam int OUT_TDATA_W    = 8;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  // Decimal digits needed for the largest magnitude, 2^(bits-1).
  function automatic int dec_digits(input int bits);
    logic [64:0] v;
    int          n;
    v = 65'd1 << (bits - 1);
    n = 0;
    for (int i = 0; i < 21; i++) begin
      if (v != 65'd0) begin
        v = v / 65'd10;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

@@ src/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
// Each input request carries one signed VALUE_BITS-bit integer; the block returns its
// decimal text one ASCII character per output request, most significant digit first,
// with a leading '-' for negative values and tlast on the final character. The front
// end takes a request and forms sign and magnitude, a two-entry queue holds it, and
// the converter runs a bit-serial binary to BCD pass and a digit search, then emits
// one character per cycle while the output is taken. The front end accepts the next
// requests while the converter is busy.
module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     in_tdata,   // value
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [OUT_TDATA_W-1:0]              out_tdata,  // char_code, zero pad
  output logic                                out_tlast
);

  logic                  q_in_valid, q_in_ready;
  logic [VALUE_BITS:0]   q_in_data;
  logic                  q_out_valid, q_out_ready;
  logic [VALUE_BITS:0]   q_out_data;
  logic [CHAR_W-1:0]     char_code;

  sitda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  sitda_queue #(.W(VALUE_BITS + 1)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_in_valid),
    .wr_ready (q_in_ready),
    .wr_data  (q_in_data),
    .rd_valid (q_out_valid),
    .rd_ready (q_out_ready),
    .rd_data  (q_out_data)
  );

  sitda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_out_valid),
    .q_ready   (q_out_ready),
    .q_data    (q_out_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (char_code),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(OUT_TDATA_W-CHAR_W){1'b0}}, char_code};

endmodule

@@ src/sitda_front.sv @@
// Front end: accept a request, split it into sign and magnitude, hand it to the queue.
module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  q_valid,
  input  logic                  q_ready,
  output logic [VALUE_BITS:0]   q_data
);

  logic                  fv_r, fv_nxt;
  logic                  fneg_r;
  logic [VALUE_BITS-1:0] fmag_r;
  logic                  take;
  logic                  neg;

  assign in_ready = !fv_r || q_ready;
  assign take     = in_valid && in_ready;
  assign neg      = in_value[VALUE_BITS-1];
  assign q_valid  = fv_r;
  assign q_data   = {fneg_r, fmag_r};

  always_comb begin
    fv_nxt = fv_r;
    if (take) begin
      fv_nxt = 1'b1;
    end else if (q_ready) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fneg_r <= neg;
      fmag_r <= neg ? (~in_value + VALUE_BITS'(1)) : in_value;
    end
  end

endmodule

@@ src/sitda_queue.sv @@
// Short request queue between the front end and the converter.
module sitda_queue
  import sitda_pkg::*;
#(
  parameter int W = VALUE_BITS_DEF + 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = cnt_r != CNT_W'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != CNT_W'(0);
  assign rd_data  = mem[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : wp_r + PTR_W'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : rp_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

@@ src/sitda_back.sv @@
// Back end: bit-serial binary to BCD conversion, then character output.
module sitda_back
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [VALUE_BITS:0]    q_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [CHAR_W-1:0]      out_char,
  output logic                   out_last
);

  localparam int NDIG  = dec_digits(VALUE_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int IDX_W = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                state_r, state_nxt;
  logic                  neg_r, neg_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  ov_r, ov_nxt;
  logic [CHAR_W-1:0]     oc_r, oc_nxt;
  logic                  ol_r, ol_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic [IDX_W-1:0]      lead;
  logic [3:0]            cur_digit;
  logic                  out_free;

  assign out_free  = !ov_r || out_ready;
  assign q_ready   = state_r == ST_IDLE;
  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;
  assign cur_digit = bcd_r[idx_r*4 +: 4];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    bcd_nxt   = bcd_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_ready;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          neg_nxt   = q_data[VALUE_BITS];
          mag_nxt   = q_data[VALUE_BITS-1:0];
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = mag_r << 1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_nxt   = lead;
        state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oc_nxt    = CHAR_MINUS;
          ol_nxt    = 1'b0;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          oc_nxt = CHAR_ZERO + {{(CHAR_W-4){1'b0}}, cur_digit};
          ol_nxt = idx_r == IDX_W'(0);
          if (idx_r == IDX_W'(0)) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    neg_r <= neg_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    idx_r <= idx_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

@@ verif/text_check_pkg.sv @@
// Expected decimal text tracker for the signed integer to ASCII testbench.
package text_check_pkg;
  import sitda_pkg::*;

  localparam int W = VALUE_BITS_DEF;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  class decimal_text_tracker;
    text_char_t expected_text[$];
    int         mismatches = 0;

    function void note_value(input logic [W-1:0] value);
      logic       negative;
      logic [W-1:0] magnitude;
      logic [3:0] digits[$];
      text_char_t ch;
      negative  = value[W-1];
      magnitude = negative ? (~value + 1'b1) : value;
      do begin
        digits.push_front(4'(magnitude % 10));
        magnitude = magnitude / 10;
      end while (magnitude != 0);
      if (negative) begin
        ch.code = CHAR_MINUS;
        ch.last = 1'b0;
        expected_text.push_back(ch);
      end
      foreach (digits[i]) begin
        ch.code = CHAR_ZERO + CHAR_W'(digits[i]);
        ch.last = (i == digits.size() - 1);
        expected_text.push_back(ch);
      end
    endfunction

    function void check_char(input logic [CHAR_W-1:0] code, input logic last);
      text_char_t want;
      if (expected_text.size() == 0) begin
        $error("char_code %0d arrived with no character pending", code);
        mismatches++;
        return;
      end
      want = expected_text.pop_front();
      if (want.code !== code) begin
        $error("char_code mismatch: expected %0d, actual %0d", want.code, code);
        mismatches++;
      end
      if (want.last !== last) begin
        $error("last_char mismatch: expected %0d, actual %0d", want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_text.size();
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// Top-level testbench for the signed integer to decimal ASCII converter.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sitda_pkg::*;
  import text_check_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_TAIL   = 60;
  localparam int RANDOM_ITEMS = 80;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [W-1:0]     in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic             out_tlast;

  decimal_text_tracker text = new();
  bit hold_off = 1'b0;
  bit no_idle  = 1'b0;
  int idle_cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [W-1:0] random_value();
    int pick;
    int k;
    logic [W-1:0] mag;
    pick = $urandom_range(0, 9);
    if (pick < 3) return $urandom();
    if (pick == 3) begin
      case ($urandom_range(0, 4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h8000_0001;
      endcase
    end
    k   = $urandom_range(1, 9);
    mag = $urandom_range(10 ** k - 1, (k == 1) ? 0 : 10 ** (k - 1));
    if ($urandom_range(0, 1)) mag = ~mag + 1'b1;
    return mag;
  endfunction

  task automatic send_value(input logic [W-1:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    text.note_value(value);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (text.pending() != 0) @(posedge clk);
  endtask

  // receiver: random ready pattern, with one long hold-off on request
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      text.check_char(out_tdata[CHAR_W-1:0], out_tlast);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[signed_int_to_decimal_ascii] ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [W-1:0] directed[$];
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 -32'sd1000000000, 32'd1999999999, 32'd123456789, -32'sd987654321,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'd7, -32'sd5};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_value(directed[i]);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_value(random_value());

    // fill the block while the output is held off
    hold_off = 1'b1;
    for (int i = 0; i < 10; i++) send_value(random_value());
    wait_drained();

    no_idle = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS / 4; i++) send_value(random_value());
    no_idle = 1'b0;
    for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_value(random_value());

    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (text.mismatches == 0 && text.pending() == 0)
      $display("[signed_int_to_decimal_ascii] OK");
    else
      $display("[signed_int_to_decimal_ascii] ERROR");
    $finish;
  end

endmodule

@@ signed_int_to_decimal_ascii.f @@
src/sitda_pkg.sv
src/sitda_front.sv
src/sitda_queue.sv
src/sitda_back.sv
src/signed_int_to_decimal_ascii.sv
verif/text_check_pkg.sv
verif/tb_top.sv
